[design/vlwc_pkg.sv]
// Types, constants and helper functions for the vertical line window classifier.
package vlwc_pkg;

  localparam int unsigned WinCols  = 5;
  localparam int unsigned WinRows  = 11;
  localparam int unsigned WinBits  = WinCols * WinRows;
  localparam int unsigned UpRows   = 4;
  localparam int unsigned LoFirst  = 5;
  localparam int unsigned LoRows   = WinRows - LoFirst;
  localparam int unsigned CentreBit = LoFirst * WinCols + 2;
  localparam int unsigned CfgData  = 5;

  typedef enum logic [1:0] {
    CfgColumnLimit = 2'd0,
    CfgPixelMax    = 2'd1,
    CfgPixelMin    = 2'd2,
    CfgRowMinimum  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VerdictOk         = 3'd0,
    VerdictSidePair   = 3'd1,
    VerdictUpperSplit = 3'd2,
    VerdictUpperLimit = 3'd3,
    VerdictLowerSplit = 3'd4,
    VerdictLowerLimit = 3'd5,
    VerdictFewRows    = 3'd6
  } verdict_e;

  localparam logic [2:0] ColumnLimitRst = 3'd3;
  localparam logic [4:0] PixelMaxRst    = 5'd6;
  localparam logic [4:0] PixelMinRst    = 5'd4;
  localparam logic [3:0] RowMinimumRst  = 4'd4;

  // Number of set bits in a five-bit column occupancy mask.
  function automatic logic [2:0] count5(input logic [4:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 5; i++) begin
      n = n + {2'b00, v[i]};
    end
    return n;
  endfunction

  // Number of set bits in the ten-bit occupied row mask.
  function automatic logic [3:0] count10(input logic [9:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 10; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  // True when the occupied columns do not form one adjacent run.
  function automatic logic is_split(input logic [4:0] v);
    logic seen;
    logic gap;
    logic split;
    seen  = 1'b0;
    gap   = 1'b0;
    split = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (v[i]) begin
        if (gap) split = 1'b1;
        seen = 1'b1;
      end else if (seen) begin
        gap = 1'b1;
      end
    end
    return split;
  endfunction

endpackage

[design/vertical_line_window_classifier_core.sv]
// Vertical line window classifier: three-stage pipeline from window to verdict.
//
// One window is taken per clock cycle; busy_o is always low. Each accepted
// transaction yields exactly one result, shown for a single cycle with done_o
// high. The result passes through three register stages: per-column counts,
// then part totals and run checks, then the limit compares.
// The receiver cannot stall, and results leave in the order windows arrived.
// Configuration registers may only be written while no transaction is in flight.
module vertical_line_window_classifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [vlwc_pkg::WinBits-1:0]  window_bits_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [vlwc_pkg::CfgData-1:0]  cfg_data_i,
  output logic                          done_o,
  output logic                          is_line_o,
  output logic [2:0]                    verdict_o
);
  import vlwc_pkg::*;

  // Configuration registers.
  logic [2:0] column_limit_q;
  logic [4:0] pixel_max_q;
  logic [4:0] pixel_min_q;
  logic [3:0] row_minimum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_limit_q <= ColumnLimitRst;
      pixel_max_q    <= PixelMaxRst;
      pixel_min_q    <= PixelMinRst;
      row_minimum_q  <= RowMinimumRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgColumnLimit: column_limit_q <= cfg_data_i[2:0];
        CfgPixelMax:    pixel_max_q    <= cfg_data_i;
        CfgPixelMin:    pixel_min_q    <= cfg_data_i;
        CfgRowMinimum:  row_minimum_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage 1: column counts and occupancy per part, row occupancy, side pair.
  logic [WinBits-1:0] win;
  logic       s1_valid_q;
  logic [2:0] s1_up_cnt_d [WinCols];
  logic [2:0] s1_up_cnt_q [WinCols];
  logic [2:0] s1_lo_cnt_d [WinCols];
  logic [2:0] s1_lo_cnt_q [WinCols];
  logic [4:0] s1_up_occ_d, s1_up_occ_q;
  logic [4:0] s1_lo_occ_d, s1_lo_occ_q;
  logic [9:0] s1_rows_d, s1_rows_q;
  logic       s1_side_d, s1_side_q;

  always_comb begin
    win = window_bits_i;
    win[CentreBit] = 1'b1;
    for (int c = 0; c < WinCols; c++) begin
      s1_up_cnt_d[c] = 3'd0;
      s1_lo_cnt_d[c] = 3'd0;
      for (int r = 0; r < UpRows; r++) begin
        s1_up_cnt_d[c] = s1_up_cnt_d[c] + {2'b00, win[r*WinCols+c]};
      end
      for (int r = LoFirst; r < WinRows; r++) begin
        s1_lo_cnt_d[c] = s1_lo_cnt_d[c] + {2'b00, win[r*WinCols+c]};
      end
      s1_up_occ_d[c] = (s1_up_cnt_d[c] != 3'd0);
      s1_lo_occ_d[c] = (s1_lo_cnt_d[c] != 3'd0);
    end
    for (int r = 0; r < UpRows; r++) begin
      s1_rows_d[r] = |win[r*WinCols +: WinCols];
    end
    for (int r = LoFirst; r < WinRows; r++) begin
      s1_rows_d[r-1] = |win[r*WinCols +: WinCols];
    end
    s1_side_d = (win[LoFirst*WinCols+3] && win[LoFirst*WinCols+4]) ||
                (win[LoFirst*WinCols+0] && win[LoFirst*WinCols+1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_up_cnt_q <= s1_up_cnt_d;
    s1_lo_cnt_q <= s1_lo_cnt_d;
    s1_up_occ_q <= s1_up_occ_d;
    s1_lo_occ_q <= s1_lo_occ_d;
    s1_rows_q   <= s1_rows_d;
    s1_side_q   <= s1_side_d;
  end

  // Stage 2: part totals, run checks, column and row counts.
  logic       s2_valid_q;
  logic [4:0] s2_up_tot_d, s2_up_tot_q;
  logic [4:0] s2_lo_tot_d, s2_lo_tot_q;
  logic       s2_up_split_q, s2_lo_split_q;
  logic [2:0] s2_up_ncol_q, s2_lo_ncol_q;
  logic [3:0] s2_rows_q;
  logic       s2_side_q;

  always_comb begin
    s2_up_tot_d = 5'd0;
    s2_lo_tot_d = 5'd0;
    for (int c = 0; c < WinCols; c++) begin
      s2_up_tot_d = s2_up_tot_d + {2'b00, s1_up_cnt_q[c]};
      s2_lo_tot_d = s2_lo_tot_d + {2'b00, s1_lo_cnt_q[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_up_tot_q   <= s2_up_tot_d;
    s2_lo_tot_q   <= s2_lo_tot_d;
    s2_up_split_q <= is_split(s1_up_occ_q);
    s2_lo_split_q <= is_split(s1_lo_occ_q);
    s2_up_ncol_q  <= count5(s1_up_occ_q);
    s2_lo_ncol_q  <= count5(s1_lo_occ_q);
    s2_rows_q     <= count10(s1_rows_q);
    s2_side_q     <= s1_side_q;
  end

  // Stage 3: limit compares and the first failing test.
  logic       done_q;
  logic       is_line_q;
  verdict_e   verdict_d, verdict_q;
  logic       up_limit, lo_limit;

  always_comb begin
    up_limit = (s2_up_ncol_q > column_limit_q) || (s2_up_tot_q > pixel_max_q) ||
               (s2_up_tot_q < pixel_min_q);
    lo_limit = (s2_lo_ncol_q > column_limit_q) || (s2_lo_tot_q > pixel_max_q) ||
               (s2_lo_tot_q < pixel_min_q);
    if (s2_side_q) begin
      verdict_d = VerdictSidePair;
    end else if (s2_up_split_q) begin
      verdict_d = VerdictUpperSplit;
    end else if (up_limit) begin
      verdict_d = VerdictUpperLimit;
    end else if (s2_lo_split_q) begin
      verdict_d = VerdictLowerSplit;
    end else if (lo_limit) begin
      verdict_d = VerdictLowerLimit;
    end else if (s2_rows_q < row_minimum_q) begin
      verdict_d = VerdictFewRows;
    end else begin
      verdict_d = VerdictOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    is_line_q <= (verdict_d == VerdictOk);
  end

  assign done_o    = done_q;
  assign is_line_o = is_line_q;
  assign verdict_o = verdict_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the vertical line window classifier core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vlwc_pkg::*;

  localparam int unsigned NumPhases  = 8;
  localparam int unsigned NumPresets = 5;
  localparam int unsigned PhaseItems = 236;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumDirected = 16;

  typedef enum logic [1:0] {
    PartPass  = 2'd0,
    PartSplit = 2'd1,
    PartLimit = 2'd2
  } part_e;

  typedef struct packed {
    logic [WinBits-1:0] win;
    logic               is_line;
    verdict_e           verdict;
  } outcome_t;

  typedef struct packed {
    logic [WinBits-1:0] win;
    logic               known;
    verdict_e           want;
  } dir_row_t;

  function automatic logic [WinBits-1:0] pix_at(input int row, input int col);
    return {{(WinBits-1){1'b0}}, 1'b1} << (row * WinCols + col);
  endfunction

  function automatic logic [WinBits-1:0] col_run(input int col, input int r0, input int r1);
    logic [WinBits-1:0] m;
    m = '0;
    for (int r = r0; r <= r1; r++) m = m | pix_at(r, col);
    return m;
  endfunction

  // Rows whose outcome is plain from the rules carry the verdict; the rest go
  // through the predictor.
  localparam dir_row_t DirectedRows [NumDirected] = '{
    '{'0, 1'b1, VerdictUpperLimit},
    '{{WinBits{1'b1}}, 1'b1, VerdictSidePair},
    '{pix_at(5, 0) | pix_at(5, 1), 1'b1, VerdictSidePair},
    '{pix_at(5, 3) | pix_at(5, 4), 1'b1, VerdictSidePair},
    '{col_run(2, 0, 3) | col_run(2, 5, 8), 1'b1, VerdictOk},
    '{col_run(2, 0, 3) | col_run(2, 5, 8) | (55'h1F << (4 * WinCols)), 1'b1, VerdictOk},
    '{pix_at(0, 0) | pix_at(0, 2), 1'b1, VerdictUpperSplit},
    '{pix_at(0, 0) | pix_at(0, 1) | pix_at(0, 2) | pix_at(0, 3), 1'b1, VerdictUpperLimit},
    '{col_run(2, 0, 3) | col_run(1, 0, 2), 1'b1, VerdictUpperLimit},
    '{col_run(2, 0, 3), 1'b1, VerdictLowerLimit},
    '{col_run(2, 0, 3) | col_run(2, 5, 8) | pix_at(6, 0), 1'b1, VerdictLowerSplit},
    '{col_run(2, 0, 3) | col_run(3, 5, 10) | col_run(2, 5, 10), 1'b1, VerdictLowerLimit},
    '{{11{5'b01010}}, 1'b0, VerdictOk},
    '{{11{5'b10101}}, 1'b0, VerdictOk},
    '{col_run(0, 0, 3) | col_run(4, 5, 10), 1'b0, VerdictOk},
    '{col_run(1, 0, 1) | col_run(2, 0, 1) | pix_at(6, 1) | pix_at(6, 2) | pix_at(6, 3),
      1'b0, VerdictOk}
  };

  // Settings of phases 1-5: zeros, widest legal, beyond range, inverted limits, tight.
  localparam logic [4:0] CfgPresets [NumPresets][4] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd5,  5'd30, 5'd0,  5'd11},
    '{5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd3,  5'd4,  5'd6,  5'd4},
    '{5'd1,  5'd4,  5'd1,  5'd2}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [WinBits-1:0] window_bits_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [CfgData-1:0] cfg_data_i;
  logic               done_o;
  logic               is_line_o;
  logic [2:0]         verdict_o;

  // Shadow copy of the configuration registers.
  logic [2:0] col_limit;
  logic [4:0] pix_max;
  logic [4:0] pix_min;
  logic [3:0] row_min;

  outcome_t    pending_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        steady = 1'b0;

  vertical_line_window_classifier_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .window_bits_i(window_bits_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .is_line_o    (is_line_o),
    .verdict_o    (verdict_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic part_e check_part(input logic [WinBits-1:0] w, input int first_row,
                                       input int end_row, inout logic [WinRows-1:0] seen);
    int unsigned total;
    int unsigned ncols;
    logic        prev;
    logic        occ;
    logic        split;
    total = 0;
    ncols = 0;
    prev  = 1'b0;
    split = 1'b0;
    for (int c = 0; c < WinCols; c++) begin
      occ = 1'b0;
      for (int r = first_row; r < end_row; r++) begin
        if (w[r * WinCols + c]) begin
          total++;
          occ     = 1'b1;
          seen[r] = 1'b1;
        end
      end
      if (occ) begin
        if (ncols != 0 && !prev) split = 1'b1;
        ncols++;
      end
      prev = occ;
    end
    if (split) return PartSplit;
    if (ncols > col_limit || total > pix_max || total < pix_min) return PartLimit;
    return PartPass;
  endfunction

  function automatic verdict_e classify_window(input logic [WinBits-1:0] raw_win);
    logic [WinBits-1:0] w;
    logic [WinRows-1:0] seen;
    int unsigned        n_rows;
    part_e              upper;
    part_e              lower;
    w            = raw_win;
    w[CentreBit] = 1'b1;
    seen         = '0;
    n_rows       = 0;
    if ((w[LoFirst * WinCols + 3] && w[LoFirst * WinCols + 4]) ||
        (w[LoFirst * WinCols + 0] && w[LoFirst * WinCols + 1])) begin
      return VerdictSidePair;
    end
    upper = check_part(w, 0, UpRows, seen);
    if (upper == PartSplit) return VerdictUpperSplit;
    if (upper == PartLimit) return VerdictUpperLimit;
    lower = check_part(w, LoFirst, WinRows, seen);
    if (lower == PartSplit) return VerdictLowerSplit;
    if (lower == PartLimit) return VerdictLowerLimit;
    for (int r = 0; r < WinRows; r++) begin
      if (seen[r]) n_rows++;
    end
    if (n_rows < row_min) return VerdictFewRows;
    return VerdictOk;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgData-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgColumnLimit: col_limit = data[2:0];
      CfgPixelMax:    pix_max   = data[4:0];
      CfgPixelMin:    pix_min   = data[4:0];
      CfgRowMinimum:  row_min   = data[3:0];
      default: ;
    endcase
  endtask

  // Offers one window, waits for the handshake and records what must come back.
  task automatic run_window(input logic [WinBits-1:0] w, input logic known, input verdict_e want);
    outcome_t    o;
    logic [63:0] noise;
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        noise = {$urandom, $urandom};
        start_i       <= 1'b0;
        window_bits_i <= noise[WinBits-1:0];
        @(posedge clk_i);
      end
    end
    start_i       <= 1'b1;
    window_bits_i <= w;
    do @(posedge clk_i); while (busy_o);
    o.win     = w;
    o.verdict = known ? want : classify_window(w);
    o.is_line = (o.verdict == VerdictOk);
    pending_outcomes.push_back(o);
  endtask

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: is_line %0d verdict %0d",
                                is_line_o, verdict_o));
      end else begin
        o = pending_outcomes.pop_front();
        if (is_line_o !== o.is_line) begin
          note_mismatch($sformatf("window %h is_line expected %0d got %0d",
                                  o.win, o.is_line, is_line_o));
        end
        if (verdict_o !== o.verdict) begin
          note_mismatch($sformatf("window %h verdict expected %0d got %0d",
                                  o.win, o.verdict, verdict_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [WinBits-1:0] w;
    logic [63:0]        raw;
    logic [CfgData-1:0] setting [4];
    int unsigned        sel;
    int unsigned        c0;
    int unsigned        c1;
    int unsigned        density;
    int unsigned        r_first;
    int unsigned        r_end;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    window_bits_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgColumnLimit;
    cfg_data_i    = '0;
    col_limit     = ColumnLimitRst;
    pix_max       = PixelMaxRst;
    pix_min       = PixelMinRst;
    row_min       = RowMinimumRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      run_window(DirectedRows[i].win, DirectedRows[i].known, DirectedRows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        // Registers change only with the pipeline empty.
        start_i <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        for (int k = 0; k < 4; k++) begin
          setting[k] = (p <= NumPresets) ? CfgPresets[p-1][k] : 5'($urandom_range(31));
        end
        write_reg(CfgColumnLimit, setting[0]);
        write_reg(CfgPixelMax, setting[1]);
        write_reg(CfgPixelMin, setting[2]);
        write_reg(CfgRowMinimum, setting[3]);
        cfg_we_i <= 1'b0;
      end
      steady = (p == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        sel = $urandom_range(19);
        if (sel == 0) begin
          raw = {$urandom, $urandom};
          w   = raw[WinBits-1:0];
        end else if (sel == 1) begin
          raw = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          w   = raw[WinBits-1:0];
        end else begin
          // Line-like window: each part filled inside a short run of columns.
          w = '0;
          for (int part = 0; part < 2; part++) begin
            c0      = $urandom_range(WinCols - 1);
            c1      = c0 + $urandom_range(2);
            if (c1 > WinCols - 1) c1 = WinCols - 1;
            density = $urandom_range(1, 5);
            r_first = (part == 0) ? 0 : LoFirst;
            r_end   = (part == 0) ? UpRows : WinRows;
            for (int r = r_first; r < r_end; r++) begin
              for (int c = c0; c <= c1; c++) begin
                if ($urandom_range(7) < density) w[r * WinCols + c] = 1'b1;
              end
            end
          end
          raw = {$urandom, $urandom};
          w[UpRows * WinCols +: WinCols] = raw[WinCols-1:0];
          if (sel < 5) w[$urandom_range(WinBits - 1)] = 1'b1;
        end
        run_window(w, 1'b0, VerdictOk);
      end
    end

    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
design/vlwc_pkg.sv
design/vertical_line_window_classifier_core.sv
tb/tb_top.sv
